// ===== rtl/merge_insertion_sorter_defines.svh =====
// ----------------------------------------------------------------------------
// Merge-insertion sorter assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MERGE_INSERTION_SORTER_DEFINES_SVH
`define MERGE_INSERTION_SORTER_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define MIS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define MIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mis_pkg.sv =====
// ----------------------------------------------------------------------------
// Merge-insertion sorter package
// Shared widths and the control word broadcast along the cell row.
// ----------------------------------------------------------------------------
package mis_pkg;

    localparam int VALUE_W = 31;

    typedef logic [VALUE_W-1:0] value_t;

    // Row-wide command for one cycle; at most one bit is set.
    typedef struct packed {
        logic ins;   // insert the broadcast value in order
        logic shl;   // shift the row one place toward cell 0
    } row_ctrl_t;

endpackage

// ===== rtl/mis_cell.sv =====
// ----------------------------------------------------------------------------
// Merge-insertion sorter cell
// One slot of the sorted row: compares against the broadcast value and
// takes its own value, its left or right neighbor's value, or the broadcast value.
// ----------------------------------------------------------------------------
module mis_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic               clk,
    input  mis_pkg::row_ctrl_t ctrl,
    input  logic [CW-1:0]      count,
    input  mis_pkg::value_t    ins_value,
    input  logic               left_gt,
    input  mis_pkg::value_t    left_value,
    input  mis_pkg::value_t    right_value,
    output mis_pkg::value_t    value,
    output logic               gt
);

    mis_pkg::value_t value_reg;
    mis_pkg::value_t value_next;
    logic            empty;

    // Unoccupied slots act as +infinity so the new value lands at the end.
    assign empty = (CW'(IDX) >= count);
    assign gt    = empty || (value_reg > ins_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins && gt)
        begin
            value_next = left_gt ? left_value : ins_value;
        end
        else if (ctrl.shl)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/merge_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// Merge-insertion sorter
// Collects a set of values, keeps it sorted in a row of cells, and emits it
// in ascending order once the final item arrives.
// ----------------------------------------------------------------------------
// Loading takes one value per cycle: every cell compares its value with the
// incoming one in parallel and the row opens a gap at the insert point, so
// the set is always in order. A value that arrives with MAX_ITEMS held is
// dropped and the overflowed flag is set for the whole set. After the final
// item's transfer, sample_ready stays low while the row shifts out toward
// cell 0, one result per cycle that result_ready is high; once the last
// result is taken the next set may start. The broadcast compare across
// the row sets the loading cycle time.
// ----------------------------------------------------------------------------
`include "merge_insertion_sorter_defines.svh"

module merge_insertion_sorter #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  logic [30:0]            sample_value,
    input  logic                   final_item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [30:0]            sorted_value,
    output logic                   last_result,
    output logic                   overflowed
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               drain_reg;
    logic               drain_next;
    logic               drop_reg;
    logic               drop_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               full;
    mis_pkg::row_ctrl_t ctrl;

    mis_pkg::value_t    cell_value [MAX_ITEMS];
    logic               cell_gt    [MAX_ITEMS];

    assign full     = (count_reg == CNT_W'(MAX_ITEMS));
    assign in_xfer  = sample_valid && sample_ready;
    assign out_xfer = result_valid && result_ready;

    assign ctrl.ins = in_xfer && !full;
    assign ctrl.shl = out_xfer;

    assign sample_ready = !drain_reg;
    assign result_valid = drain_reg;
    assign sorted_value = cell_value[0];
    assign last_result  = (count_reg == CNT_W'(1));
    assign overflowed   = drop_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++)
        begin : g_cell
            logic            left_gt;
            mis_pkg::value_t left_value;
            mis_pkg::value_t right_value;

            if (gi == 0)
            begin : g_first
                assign left_gt    = 1'b0;
                assign left_value = cell_value[gi];
            end
            else
            begin : g_inner_l
                assign left_gt    = cell_gt[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == MAX_ITEMS - 1)
            begin : g_last
                assign right_value = cell_value[gi];
            end
            else
            begin : g_inner_r
                assign right_value = cell_value[gi+1];
            end

            mis_cell #(
                .IDX (gi),
                .CW  (CNT_W)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .ins_value   (sample_value),
                .left_gt     (left_gt),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (cell_value[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        drain_next = drain_reg;
        drop_next  = drop_reg;
        if (in_xfer)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (final_item)
            begin
                drain_next = 1'b1;
            end
        end
        if (out_xfer)
        begin
            count_next = count_reg - CNT_W'(1);
            if (last_result)
            begin
                drain_next = 1'b0;
                drop_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drain_reg <= 1'b0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drain_reg <= drain_next;
            drop_reg  <= drop_next;
        end
    end

    `MIS_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(MAX_ITEMS), "count above capacity")
    `MIS_ASSERT_ALWAYS(a_drain_nonempty, !drain_reg || count_reg != '0, "emitting an empty set")
    `MIS_ASSERT_NEXT(a_set_closed, out_xfer && last_result, !drain_reg && count_reg == '0 && !drop_reg, "set not cleared after last result")
    `MIS_ASSERT_NEXT(a_drop_sticky, drop_reg && !drain_reg, drop_reg, "drop flag lost while loading")

endmodule

// ===== sim/merge_insertion_sorter_check.sv =====
// ----------------------------------------------------------------------------
// Merge-insertion sorter checker
// Watches both channels. It keeps its own sorted copy of the set being loaded
// and queues the expected output run when the final transfer arrives. Each
// result transfer is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module merge_insertion_sorter_check #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    input  logic            sample_ready,
    input  mis_pkg::value_t sample_value,
    input  logic            final_item,
    input  logic            result_valid,
    input  logic            result_ready,
    input  mis_pkg::value_t sorted_value,
    input  logic            last_result,
    input  logic            overflowed,
    output int              failures,
    output int              outstanding
);

    typedef struct packed {
        mis_pkg::value_t value;
        logic            last;
        logic            dropped;
    } sorted_entry_t;

    mis_pkg::value_t held_set[$];
    logic            drop_seen = 1'b0;
    sorted_entry_t   sorted_run[$];
    int              fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        int            pos;
        sorted_entry_t want;
        if (!rst_n)
        begin
            held_set.delete();
            sorted_run.delete();
            drop_seen = 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (sorted_run.size() == 0)
                begin
                    $error("unexpected result: sorted_value %0d", sorted_value);
                    fail_count++;
                end
                else
                begin
                    want = sorted_run.pop_front();
                    if (sorted_value !== want.value)
                    begin
                        $error("sorted_value: expected %0d, actual %0d",
                               want.value, sorted_value);
                        fail_count++;
                    end
                    if (last_result !== want.last)
                    begin
                        $error("last_result: expected %0d, actual %0d",
                               want.last, last_result);
                        fail_count++;
                    end
                    if (overflowed !== want.dropped)
                    begin
                        $error("overflowed: expected %0d, actual %0d",
                               want.dropped, overflowed);
                        fail_count++;
                    end
                end
            end

            if (sample_valid && sample_ready)
            begin
                // new value goes after every held value not greater than it
                if (held_set.size() < CAPACITY)
                begin
                    pos = held_set.size();
                    while (pos > 0 && held_set[pos-1] > sample_value)
                        pos--;
                    held_set.insert(pos, sample_value);
                end
                else
                begin
                    drop_seen = 1'b1;
                end
                if (final_item)
                begin
                    foreach (held_set[k])
                    begin
                        want = '{held_set[k], k == held_set.size() - 1, drop_seen};
                        sorted_run.insert(sorted_run.size(), want);
                    end
                    held_set.delete();
                    drop_seen = 1'b0;
                end
            end
        end
        failures    <= fail_count;
        outstanding <= sorted_run.size();
    end

endmodule

// ===== sim/merge_insertion_sorter_test.sv =====
// ----------------------------------------------------------------------------
// Merge-insertion sorter testbench
// Loads sets of values with random gaps and result back-pressure: a few
// directed sets on extremes, duplicates and order, then random sets, some
// past capacity. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module merge_insertion_sorter_test;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 360;

    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            sample_valid = 1'b0;
    logic            sample_ready;
    mis_pkg::value_t sample_value = '0;
    logic            final_item   = 1'b0;
    logic            result_valid;
    logic            result_ready = 1'b0;
    mis_pkg::value_t sorted_value;
    logic            last_result;
    logic            overflowed;
    int              failures;
    int              outstanding;
    int              items_sent    = 0;
    int              results_taken = 0;
    mis_pkg::value_t set_vals[$];

    always #5 clk = ~clk;

    merge_insertion_sorter #(
        .MAX_ITEMS(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .final_item   (final_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflowed   (overflowed)
    );

    merge_insertion_sorter_check #(
        .CAPACITY(CAPACITY)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_value (sample_value),
        .final_item   (final_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflowed   (overflowed),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    // result side: random stalls, except for a stretch of steady draining
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
                results_taken <= results_taken + 1;
            if (results_taken >= 100 && results_taken < 220)
                result_ready <= 1'b1;
            else
                result_ready <= ($urandom_range(0, 99) >= 19);
        end
    end

    function automatic mis_pkg::value_t pick_value();
        int sel = $urandom_range(0, 99);
        if (sel < 40)
            return mis_pkg::value_t'($urandom);
        else if (sel < 70)
            return mis_pkg::value_t'($urandom_range(0, 15));     // duplicates likely
        else if (sel < 85)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        else
            return '1 - mis_pkg::value_t'($urandom_range(0, 15));
    endfunction

    // sends set_vals as one set, final flag on the last value
    task automatic send_set();
        for (int k = 0; k < set_vals.size(); k++)
        begin
            while (!(items_sent >= 150 && items_sent < 230)
                   && $urandom_range(0, 99) < 19)
            begin
                sample_valid <= 1'b0;
                @(posedge clk);
            end
            sample_valid <= 1'b1;
            sample_value <= set_vals[k];
            final_item   <= (k == set_vals.size() - 1);
            @(posedge clk);
            while (!sample_ready)
                @(posedge clk);
            items_sent++;
        end
        set_vals.delete();
    endtask

    initial
    begin
        int set_no;
        int set_len;
        int stop_at;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-value sets at both extremes
        set_vals = '{31'h7FFF_FFFF};
        send_set();
        set_vals = '{31'h0};
        send_set();
        // unordered, with duplicates and alternating bit patterns
        set_vals = '{31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA, 31'h0,
                     31'h5555_5555, 31'h1};
        send_set();
        // already in order
        set_vals = '{31'h1, 31'h2, 31'h4, 31'h4000_0000};
        send_set();
        // all equal
        set_vals = '{31'h7, 31'h7, 31'h7};
        send_set();

        stop_at = items_sent + RANDOM_ITEMS;
        set_no  = 0;
        while (items_sent < stop_at)
        begin
            // a few sets fill the store exactly or overrun it
            case (set_no)
                1:       set_len = CAPACITY + 1;
                3:       set_len = CAPACITY;
                5:       set_len = CAPACITY + 6;
                default: set_len = ($urandom_range(0, 5) == 0)
                                   ? $urandom_range(CAPACITY - 2, CAPACITY + 4)
                                   : $urandom_range(1, 10);
            endcase
            repeat (set_len)
                set_vals.insert(set_vals.size(), pick_value());
            send_set();
            set_no++;
        end
        sample_valid <= 1'b0;
        final_item   <= 1'b0;

        // let the checker queue the last run before watching it drain
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0 && outstanding == 0)
            $display("merge_insertion_sorter: match");
        else
            $display("merge_insertion_sorter: mismatch");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("merge_insertion_sorter: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mis_pkg.sv
rtl/mis_cell.sv
rtl/merge_insertion_sorter.sv
sim/merge_insertion_sorter_check.sv
sim/merge_insertion_sorter_test.sv
